>>> hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Types and constants shared by the proxy rule tokenizer modules.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned PORT_W = 31;

  localparam logic [PORT_W-1:0] PORT_MAX = {PORT_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;

  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_DOM     = 4'd1,
    PH_DOMSP   = 4'd2,
    PH_PATH    = 4'd3,
    PH_PATHSP  = 4'd4,
    PH_SRVLEAD = 4'd5,
    PH_SRV     = 4'd6,
    PH_PORT    = 4'd7,
    PH_TAIL    = 4'd8,
    PH_ERR     = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_DOMAIN = 3'd1,
    ST_NO_COLON   = 3'd2,
    ST_BAD_PORT   = 3'd3,
    ST_EXTRA      = 3'd4,
    ST_EMPTY_SRV  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ROLE_SKIP   = 3'd0,
    ROLE_DOMAIN = 3'd1,
    ROLE_PATH   = 3'd2,
    ROLE_SERVER = 3'd3,
    ROLE_PORT   = 3'd4
  } role_t;

  typedef struct packed {
    phase_t              phase;
    logic [PORT_W-1:0]   accum;
    status_t             err;
  } tok_state_t;

  typedef struct packed {
    role_t               role;
    logic                rule_end;
    status_t             status;
    logic [PORT_W-1:0]   port;
  } tok_result_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> hdl/prt_step.sv
// ----------------------------------------------------------------------------
// prt_step
// Phase machine for one rule byte: next phase, port accumulate, first error
// and the result fields for that byte.
// ----------------------------------------------------------------------------
module prt_step (
  input  logic [prt_pkg::CHAR_W-1:0] ch,
  input  prt_pkg::tok_state_t        cur,
  output prt_pkg::tok_state_t        nxt,
  output prt_pkg::tok_result_t       res
);
  import prt_pkg::*;

  localparam int unsigned PROD_W = PORT_W + 4;

  logic                sp;
  logic                digit;
  logic [3:0]          dig_val;
  logic [PROD_W-1:0]   prod;
  logic                ovf;
  logic                term;
  phase_t              eff;
  status_t             term_err;

  assign sp      = is_space(ch);
  assign digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig_val = 4'(ch - CH_ZERO);
  // accum * 10 + digit as two shifts and two adds
  assign prod    = ({4'b0000, cur.accum} << 3) + ({4'b0000, cur.accum} << 1)
                 + PROD_W'(dig_val);
  assign ovf     = prod > PROD_W'(PORT_MAX);
  assign term    = (ch == CH_NUL);
  // first non-space byte of a rule is handled as domain
  assign eff     = ((cur.phase == PH_LEAD) && !sp) ? PH_DOM : cur.phase;

  always_comb begin
    term_err = cur.err;
    if (cur.phase == PH_SRV) begin
      term_err = ST_NO_COLON;
    end else if ((cur.phase == PH_PORT) && (cur.accum == '0)) begin
      term_err = ST_BAD_PORT;
    end
  end

  // next state
  always_comb begin
    nxt       = cur;
    nxt.phase = eff;
    if (term) begin
      nxt.phase = PH_LEAD;
      nxt.accum = '0;
      nxt.err   = ST_OK;
    end else begin
      unique case (eff)
        PH_LEAD: ;
        PH_DOM: begin
          if (ch == CH_SLASH) nxt.phase = PH_PATH;
          else if (ch == CH_BAR) nxt.phase = PH_SRVLEAD;
          else if (sp) nxt.phase = PH_DOMSP;
        end
        PH_DOMSP: begin
          if (ch == CH_BAR) nxt.phase = PH_SRVLEAD;
          else if (!sp) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_BAD_DOMAIN;
          end
        end
        PH_PATH: begin
          if (ch == CH_BAR) nxt.phase = PH_SRVLEAD;
          else if (sp) nxt.phase = PH_PATHSP;
        end
        PH_PATHSP: begin
          if (ch == CH_BAR) nxt.phase = PH_SRVLEAD;
          else if (!sp) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_EXTRA;
          end
        end
        PH_SRVLEAD: begin
          if (ch == CH_COLON) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_EMPTY_SRV;
          end else if (!sp) nxt.phase = PH_SRV;
        end
        PH_SRV: begin
          if (ch == CH_COLON) nxt.phase = PH_PORT;
          else if (sp) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_NO_COLON;
          end
        end
        PH_PORT: begin
          if (digit && !ovf) begin
            nxt.accum = prod[PORT_W-1:0];
          end else if (sp && (cur.accum != '0)) begin
            nxt.phase = PH_TAIL;
          end else begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_BAD_PORT;
          end
        end
        PH_TAIL: begin
          if (!sp) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_EXTRA;
          end
        end
        default: nxt.phase = PH_ERR;
      endcase
    end
  end

  // result fields
  always_comb begin
    res.role     = ROLE_SKIP;
    res.rule_end = term;
    res.status   = term ? term_err : nxt.err;
    res.port     = term ? cur.accum : nxt.accum;
    if (!term) begin
      unique case (eff)
        PH_DOM: begin
          if (ch == CH_SLASH) res.role = ROLE_PATH;
          else if ((ch != CH_BAR) && !sp) res.role = ROLE_DOMAIN;
        end
        PH_PATH: begin
          if ((ch != CH_BAR) && !sp) res.role = ROLE_PATH;
        end
        PH_SRVLEAD: begin
          if ((ch != CH_COLON) && !sp) res.role = ROLE_SERVER;
        end
        PH_SRV: begin
          if ((ch != CH_COLON) && !sp) res.role = ROLE_SERVER;
        end
        PH_PORT: begin
          if (digit && !ovf) res.role = ROLE_PORT;
        end
        default: res.role = ROLE_SKIP;
      endcase
    end
  end

endmodule

>>> hdl/proxy_rule_tokenizer.sv
// ----------------------------------------------------------------------------
// proxy_rule_tokenizer
// Byte-wise tokenizer for proxy rules of the form "domain/path | server:port".
// ----------------------------------------------------------------------------
// Feed one rule byte per request on ch; a zero byte ends the rule. Every byte
// gives one result: its role, the running port value and the first error seen
// in the rule, which holds until the terminator. The terminator result carries
// rule_end, the final status and port, and the block is then ready for the
// next rule. One byte is taken every clock cycle while char_stall is low; the
// byte is held in the input register, and its result is loaded into the result
// register when the output is not stalled. The rate is set by the phase and
// port update, a loop of shift-add times ten, range check and phase decode
// between the input register and the state and result registers.
module proxy_rule_tokenizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  output logic                        char_stall,
  input  logic [prt_pkg::CHAR_W-1:0]  ch,
  output logic                        tok_valid,
  input  logic                        tok_stall,
  output logic [2:0]                  char_role,
  output logic                        rule_end,
  output logic [2:0]                  status,
  output logic [prt_pkg::PORT_W-1:0]  port_value
);
  import prt_pkg::*;

  logic                 s1_valid;
  logic [CHAR_W-1:0]    s1_ch;
  tok_state_t           state;
  tok_state_t           state_next;
  tok_result_t          res_next;
  tok_result_t          res;
  logic                 advance;

  prt_step u_step (
    .ch  (s1_ch),
    .cur (state),
    .nxt (state_next),
    .res (res_next)
  );

  assign advance    = !tok_valid || !tok_stall;
  assign char_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      tok_valid   <= 1'b0;
      state.phase <= PH_LEAD;
      state.accum <= '0;
      state.err   <= ST_OK;
    end else begin
      if (!char_stall) s1_valid <= char_valid;
      if (advance) begin
        tok_valid <= s1_valid;
        if (s1_valid) state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) s1_ch <= ch;
    if (advance && s1_valid) res <= res_next;
  end

  assign char_role  = res.role;
  assign rule_end   = res.rule_end;
  assign status     = res.status;
  assign port_value = res.port;

  // error status and the held-error phase always go together
  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    (state.err != ST_OK) == (state.phase == PH_ERR))
    else $error("error status and phase disagree");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && (s1_ch == CH_NUL)) |=>
      ((state.phase == PH_LEAD) && (state.accum == '0) && (state.err == ST_OK)))
    else $error("state not cleared after rule end");

  a_end_role: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && rule_end) |-> (char_role == ROLE_SKIP))
    else $error("terminator carries a role");

  a_port_ok: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && (char_role == ROLE_PORT)) |-> (status == ST_OK))
    else $error("port digit tagged under an error");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (s1_valid && tok_valid))
    else $error("request stalled with room to take it");

endmodule

>>> dv/rule_token_checker.sv
// ----------------------------------------------------------------------------
// rule_token_checker
// Watches both channels of the proxy rule tokenizer and checks every result.
// ----------------------------------------------------------------------------
// Each accepted rule byte runs through a local model of the rule phase machine
// and port accumulator. The model keeps its own phase, port and held error.
// The predicted token is queued, and each accepted result is compared field by
// field with the oldest queued token.
// ----------------------------------------------------------------------------
module rule_token_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  input  logic                         char_stall,
  input  logic [prt_pkg::CHAR_W-1:0]   ch,
  input  logic                         tok_valid,
  input  logic                         tok_stall,
  input  logic [2:0]                   char_role,
  input  logic                         rule_end,
  input  logic [2:0]                   status,
  input  logic [prt_pkg::PORT_W-1:0]   port_value,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import prt_pkg::*;

  phase_t             cur_phase;
  logic [PORT_W-1:0]  cur_port;
  status_t            cur_err;
  tok_result_t        expected_tokens[$];

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic void flag_error(input status_t code);
    cur_err   = code;
    cur_phase = PH_ERR;
  endfunction

  // Advance the rule model by one byte and return the token it gives.
  function automatic tok_result_t tokenize_byte(input logic [CHAR_W-1:0] c);
    tok_result_t        tok;
    logic [PORT_W+3:0]  grown;
    tok.role     = ROLE_SKIP;
    tok.rule_end = 1'b0;
    if (c == CH_NUL) begin
      if (cur_phase == PH_SRV) flag_error(ST_NO_COLON);
      else if (cur_phase == PH_PORT && cur_port == '0) flag_error(ST_BAD_PORT);
      tok.rule_end = 1'b1;
      tok.status   = cur_err;
      tok.port     = cur_port;
      cur_phase    = PH_LEAD;
      cur_port     = '0;
      cur_err      = ST_OK;
      return tok;
    end
    if (cur_phase == PH_LEAD && !is_blank(c)) cur_phase = PH_DOM;
    case (cur_phase)
      PH_LEAD: ;
      PH_DOM: begin
        if (c == CH_SLASH) begin
          tok.role  = ROLE_PATH;
          cur_phase = PH_PATH;
        end else if (c == CH_BAR) cur_phase = PH_SRVLEAD;
        else if (is_blank(c)) cur_phase = PH_DOMSP;
        else tok.role = ROLE_DOMAIN;
      end
      PH_DOMSP: begin
        if (c == CH_BAR) cur_phase = PH_SRVLEAD;
        else if (!is_blank(c)) flag_error(ST_BAD_DOMAIN);
      end
      PH_PATH: begin
        if (c == CH_BAR) cur_phase = PH_SRVLEAD;
        else if (is_blank(c)) cur_phase = PH_PATHSP;
        else tok.role = ROLE_PATH;
      end
      PH_PATHSP: begin
        if (c == CH_BAR) cur_phase = PH_SRVLEAD;
        else if (!is_blank(c)) flag_error(ST_EXTRA);
      end
      PH_SRVLEAD: begin
        if (c == CH_COLON) flag_error(ST_EMPTY_SRV);
        else if (!is_blank(c)) begin
          tok.role  = ROLE_SERVER;
          cur_phase = PH_SRV;
        end
      end
      PH_SRV: begin
        if (c == CH_COLON) cur_phase = PH_PORT;
        else if (is_blank(c)) flag_error(ST_NO_COLON);
        else tok.role = ROLE_SERVER;
      end
      PH_PORT: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          grown = (PORT_W+4)'(cur_port) * (PORT_W+4)'(10) + (PORT_W+4)'(c - CH_ZERO);
          // on overflow keep the last good port
          if (grown > (PORT_W+4)'(PORT_MAX)) flag_error(ST_BAD_PORT);
          else begin
            cur_port = grown[PORT_W-1:0];
            tok.role = ROLE_PORT;
          end
        end else if (is_blank(c)) begin
          if (cur_port == '0) flag_error(ST_BAD_PORT);
          else cur_phase = PH_TAIL;
        end else flag_error(ST_BAD_PORT);
      end
      PH_TAIL: begin
        if (!is_blank(c)) flag_error(ST_EXTRA);
      end
      default: cur_phase = PH_ERR;
    endcase
    tok.status = cur_err;
    tok.port   = cur_port;
    return tok;
  endfunction

  always @(posedge clk) begin : watch
    tok_result_t want;
    if (rst) begin
      cur_phase = PH_LEAD;
      cur_port  = '0;
      cur_err   = ST_OK;
      expected_tokens.delete();
    end else begin
      if (char_valid && !char_stall) expected_tokens.push_back(tokenize_byte(ch));
      if (tok_valid && !tok_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: role %0d end %0d status %0d port %0d",
                 char_role, rule_end, status, port_value);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          checked++;
          if (char_role !== want.role) begin
            $error("char_role: expected %0d, got %0d", want.role, char_role);
            errors++;
          end
          if (rule_end !== want.rule_end) begin
            $error("rule_end: expected %0d, got %0d", want.rule_end, rule_end);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (port_value !== want.port) begin
            $error("port_value: expected %0d, got %0d", want.port, port_value);
            errors++;
          end
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the proxy rule tokenizer.
// ----------------------------------------------------------------------------
// A short directed set of rules hits each byte role and each syntax error.
// It is followed by random rules: mostly well formed with random content, the
// rest mutated or pure noise. These run under four flow-control settings. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prt_pkg::*;

  localparam int PHASE_BYTES  = 100;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 8;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_stall;
  logic [CHAR_W-1:0]  ch         = '0;
  logic               tok_valid;
  logic               tok_stall  = 1'b0;
  logic [2:0]         char_role;
  logic               rule_end;
  logic [2:0]         status;
  logic [PORT_W-1:0]  port_value;

  int fail_count;
  int pending_count;
  int checked_count;
  int send_idle_pct;
  int stall_pct;
  int cycle_count;
  int bytes_sent;
  int rules_sent;

  logic [CHAR_W-1:0] rule_bytes[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  proxy_rule_tokenizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ch         (ch),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .char_role  (char_role),
    .rule_end   (rule_end),
    .status     (status),
    .port_value (port_value)
  );

  rule_token_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ch         (ch),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .char_role  (char_role),
    .rule_end   (rule_end),
    .status     (status),
    .port_value (port_value),
    .errors     (fail_count),
    .pending    (pending_count),
    .checked    (checked_count)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("proxy_rule_tokenizer: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    tok_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [CHAR_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    char_valid <= 1'b1;
    ch         <= b;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain();
    char_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_rule();
    foreach (rule_bytes[i]) begin
      if ($urandom_range(199) == 0) drain();
      send_byte(rule_bytes[i]);
    end
    send_byte(CH_NUL);
    rules_sent++;
    rule_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) rule_bytes.push_back(s[i]);
  endtask

  task automatic add_blanks(input int lo, input int hi);
    int pick;
    repeat ($urandom_range(hi, lo)) begin
      pick = $urandom_range(5);
      rule_bytes.push_back(pick == 5 ? CH_SPACE : CH_TAB + CHAR_W'(pick));
    end
  endtask

  function automatic logic [CHAR_W-1:0] plain_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(255, 1));
    while (b inside {[8'd9:8'd13], CH_SPACE, CH_SLASH, CH_BAR, CH_COLON});
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] special_byte();
    case ($urandom_range(6))
      0:       return CH_SLASH;
      1:       return CH_BAR;
      2:       return CH_COLON;
      3:       return CH_SPACE;
      4:       return CH_TAB;
      5:       return CH_ZERO + CHAR_W'($urandom_range(9));
      default: return "a";
    endcase
  endfunction

  task automatic add_word(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) rule_bytes.push_back(plain_byte());
  endtask

  function automatic longint unsigned pick_port();
    case ($urandom_range(9))
      6:       return 64'd2147483647;
      7:       return 64'd2147483648 + longint'($urandom_range(1000000));
      8:       return longint'($urandom_range(32'h7FFF_FFFF));
      9:       return 64'd0;
      default: return longint'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic add_port_digits(input longint unsigned n);
    logic [CHAR_W-1:0] rev[$];
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) rule_bytes.push_back(CH_ZERO);
    do begin
      rev.push_front(CH_ZERO + CHAR_W'(n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (rev[i]) rule_bytes.push_back(rev[i]);
  endtask

  task automatic build_good();
    add_blanks(0, 2);
    if ($urandom_range(9) != 0) add_word(1, 8);
    if ($urandom_range(1) == 1) begin
      rule_bytes.push_back(CH_SLASH);
      add_word(0, 6);
    end
    add_blanks(0, 2);
    if ($urandom_range(7) != 0) begin
      rule_bytes.push_back(CH_BAR);
      add_blanks(0, 2);
      if ($urandom_range(9) != 0) begin
        add_word(1, 6);
        rule_bytes.push_back(CH_COLON);
        add_port_digits(pick_port());
        add_blanks(0, 2);
      end
    end
  endtask

  task automatic build_rule();
    int kind;
    int pos;
    kind = $urandom_range(99);
    if (kind < 70) build_good();
    else if (kind < 90) begin
      build_good();
      if (rule_bytes.size() == 0) rule_bytes.push_back(special_byte());
      else begin
        pos = $urandom_range(rule_bytes.size() - 1);
        case ($urandom_range(2))
          0:       rule_bytes.insert(pos, special_byte());
          1:       rule_bytes.delete(pos);
          default: rule_bytes[pos] = CHAR_W'($urandom_range(255, 1));
        endcase
      end
    end else begin
      // noise; a zero byte inside ends the rule early
      repeat ($urandom_range(12, 1))
        rule_bytes.push_back($urandom_range(3) == 0 ? special_byte()
                                                    : CHAR_W'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int phase_start;
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 57, 0, 27};
    stall_set = '{0, 0, 57, 27};
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every role, the byte extremes and a leading blank
    rule_bytes.push_back(CH_TAB);
    add_text("a");
    rule_bytes.push_back(8'hFF);
    add_text("/|s:9");
    send_rule();
    // stray byte after the domain space
    rule_bytes.push_back(8'h01);
    rule_bytes.push_back(CH_CR);
    add_text("x");
    send_rule();
    // server ended by the terminator without a colon
    add_text("|s");
    send_rule();
    // colon straight after the bar
    add_text("|:");
    send_rule();
    // port with no digits
    add_text("|s:");
    send_rule();
    // extra text after the path
    add_text("/ x");
    send_rule();
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      phase_start   = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_rule();
        send_rule();
      end
      drain();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d rules (%0d bytes) under four sender/receiver flow settings;",
             rules_sent, bytes_sent);
    $display("%0d tokens compared for role, end flag, status and port.", checked_count);
    if (fail_count == 0) begin
      $display("proxy_rule_tokenizer: match");
    end else begin
      $display("proxy_rule_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
